// ----- hdl/ali_pkg.sv -----
// Shared types and constants for the array list block.
package ali_pkg;

	localparam int DATA_W = 32;
	localparam int CNT_W  = 7;
	localparam int CMD_W  = 3;
	localparam int GRP_N  = 8;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND   = 3'd0,
		CMD_DEL_LAST = 3'd1,
		CMD_INSERT   = 3'd2,
		CMD_DEL_AT   = 3'd3,
		CMD_DUMP     = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BOUNDS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_APPEND,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} cell_op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FINISH,
		S_DUMP
	} state_t;

	// Broadcast to every cell of the row
	typedef struct packed {
		cell_op_t                  op;
		logic [CNT_W-1:0]          pos;
		logic [CNT_W-1:0]          cnt;
		logic signed [DATA_W-1:0]  value;
		logic                      rd_en;
		logic [CNT_W-1:0]          rd_addr;
	} ctl_t;

endpackage

// ----- hdl/ali_cell.sv -----
// One storage cell of the list row: holds one entry and trades it with its neighbors.
module ali_cell #(
	parameter int IDX = 0
) (
	input  logic                              clk,
	input  ali_pkg::ctl_t                     ctl,
	input  logic signed [ali_pkg::DATA_W-1:0] left_data,
	input  logic signed [ali_pkg::DATA_W-1:0] right_data,
	input  logic signed [ali_pkg::DATA_W-1:0] head_data,
	output logic signed [ali_pkg::DATA_W-1:0] data,
	output logic signed [ali_pkg::DATA_W-1:0] rd_data
);
	import ali_pkg::*;

	localparam logic [CNT_W-1:0] IDX_V = CNT_W'(IDX);

	logic signed [DATA_W-1:0] data_q;
	logic signed [DATA_W-1:0] data_d;
	logic [CNT_W:0]           idx_inc;
	logic [CNT_W:0]           cnt_x;

	assign idx_inc = {1'b0, IDX_V} + 1'b1;
	assign cnt_x   = {1'b0, ctl.cnt};

	// next entry value from the broadcast edit
	always_comb begin
		data_d = data_q;
		case (ctl.op)
			OP_APPEND: begin
				if (IDX_V == ctl.cnt) data_d = ctl.value;
			end
			OP_INSERT: begin
				if (IDX_V == ctl.pos) data_d = ctl.value;
				else if (IDX_V > ctl.pos && IDX_V <= ctl.cnt) data_d = left_data;
			end
			OP_DELETE: begin
				if (IDX_V >= ctl.pos && idx_inc < cnt_x) data_d = right_data;
			end
			OP_ROTATE: begin
				if (idx_inc < cnt_x) data_d = right_data;
				else if (idx_inc == cnt_x) data_d = head_data;
			end
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data    = data_q;
	assign rd_data = (ctl.rd_en && ctl.rd_addr == IDX_V) ? data_q : '0;

endmodule

// ----- hdl/ali_chain.sv -----
// Row of list cells plus the registered OR tree that reads one entry out.
module ali_chain #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  ali_pkg::ctl_t                     ctl,
	output logic signed [ali_pkg::DATA_W-1:0] head_data,
	output logic signed [ali_pkg::DATA_W-1:0] read_data
);
	import ali_pkg::*;

	localparam int NGRP = (CAPACITY + GRP_N - 1) / GRP_N;

	logic signed [DATA_W-1:0] data_w [CAPACITY];
	logic signed [DATA_W-1:0] rd_w   [NGRP*GRP_N];
	logic [DATA_W-1:0]        grp_q  [NGRP];

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			logic signed [DATA_W-1:0] left_w;
			logic signed [DATA_W-1:0] right_w;
			if (gi == 0) begin : g_first
				assign left_w = '0;
			end else begin : g_mid_l
				assign left_w = data_w[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign right_w = '0;
			end else begin : g_mid_r
				assign right_w = data_w[gi+1];
			end
			ali_cell #(.IDX(gi)) u_cell (
				.clk        (clk),
				.ctl        (ctl),
				.left_data  (left_w),
				.right_data (right_w),
				.head_data  (data_w[0]),
				.data       (data_w[gi]),
				.rd_data    (rd_w[gi])
			);
		end
		for (gi = CAPACITY; gi < NGRP*GRP_N; gi++) begin : g_pad
			assign rd_w[gi] = '0;
		end
	endgenerate

	// first tree level: OR of each group of cells, registered
	always_ff @(posedge clk) begin
		for (int g = 0; g < NGRP; g++) begin
			logic [DATA_W-1:0] acc;
			acc = '0;
			for (int k = 0; k < GRP_N; k++) acc = acc | rd_w[g*GRP_N + k];
			grp_q[g] <= acc;
		end
	end

	// second tree level
	always_comb begin
		logic [DATA_W-1:0] acc;
		acc = '0;
		for (int g = 0; g < NGRP; g++) acc = acc | grp_q[g];
		read_data = signed'(acc);
	end

	assign head_data = data_w[0];

endmodule

// ----- hdl/array_list_insert_delete.sv -----
// Edit commands give their result in the output register by way of the FINISH state.
// A new request waits out FINISH, which waits on the registered read tree of the cell row.
// Dump: count results from the row head as it rotates once, one per cycle if output is free.
// Reset clears the entry count, the controller and the output valid; entries are unset.
// Entries are read only below the count, so no clearing pass is needed.
module array_list_insert_delete #(
	parameter int CAPACITY = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // command[2:0], position[9:3], value[41:10], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // status[1:0], data_out[33:2], length[40:34], zero pad
	output logic        m_tlast
);
	import ali_pkg::*;

	localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAPACITY);

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         cnt_q, cnt_d;
	logic [CNT_W-1:0]         dump_idx_q, dump_idx_d;
	status_t                  status_s1, status_d;
	logic                     accept;
	logic                     out_load;
	logic                     out_valid_q;
	status_t                  out_status_q, out_status_d;
	logic signed [DATA_W-1:0] out_data_q, out_data_d;
	logic [CNT_W-1:0]         out_len_q, out_len_d;
	logic                     out_last_q, out_last_d;
	logic [CMD_W-1:0]         in_cmd;
	logic [CNT_W-1:0]         in_pos;
	logic signed [DATA_W-1:0] in_value;
	logic signed [DATA_W-1:0] head_data;
	logic signed [DATA_W-1:0] read_data;
	logic                     out_free;
	ctl_t                     ctl;

	assign in_cmd   = s_tdata[2:0];
	assign in_pos   = s_tdata[9:3];
	assign in_value = signed'(s_tdata[41:10]);

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	ali_chain #(.CAPACITY(CAPACITY)) u_chain (
		.clk       (clk),
		.ctl       (ctl),
		.head_data (head_data),
		.read_data (read_data)
	);

	// command decode, next state and output register load
	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		dump_idx_d   = dump_idx_q;
		status_d     = status_s1;
		out_load     = 1'b0;
		out_status_d = out_status_q;
		out_data_d   = out_data_q;
		out_len_d    = out_len_q;
		out_last_d   = out_last_q;
		ctl.op       = OP_NONE;
		ctl.pos      = in_pos;
		ctl.cnt      = cnt_q;
		ctl.value    = in_value;
		ctl.rd_en    = 1'b0;
		ctl.rd_addr  = in_pos;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d  = S_FINISH;
					status_d = STAT_OK;
					case (in_cmd)
						CMD_APPEND: begin
							if (cnt_q >= CAP_V) status_d = STAT_FULL;
							else begin
								ctl.op = OP_APPEND;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						CMD_DEL_LAST: begin
							if (cnt_q == '0) status_d = STAT_EMPTY;
							else begin
								ctl.rd_en   = 1'b1;
								ctl.rd_addr = cnt_q - 1'b1;
								cnt_d       = cnt_q - 1'b1;
							end
						end
						CMD_INSERT: begin
							if (cnt_q >= CAP_V) status_d = STAT_FULL;
							else if (in_pos > cnt_q) status_d = STAT_BOUNDS;
							else begin
								ctl.op = OP_INSERT;
								cnt_d  = cnt_q + 1'b1;
							end
						end
						CMD_DEL_AT: begin
							if (in_pos >= cnt_q) status_d = STAT_BOUNDS;
							else begin
								ctl.op    = OP_DELETE;
								ctl.rd_en = 1'b1;
								cnt_d     = cnt_q - 1'b1;
							end
						end
						CMD_DUMP: begin
							if (cnt_q == '0) status_d = STAT_EMPTY;
							else begin
								state_d    = S_DUMP;
								dump_idx_d = '0;
							end
						end
						default: status_d = STAT_OK;
					endcase
				end
			end
			S_FINISH: begin
				// output register is free here: s_tready demanded it at the request
				out_load     = 1'b1;
				out_status_d = status_s1;
				out_data_d   = read_data;
				out_len_d    = cnt_q;
				out_last_d   = 1'b1;
				state_d      = S_IDLE;
			end
			S_DUMP: begin
				if (out_free) begin
					ctl.op       = OP_ROTATE;
					out_load     = 1'b1;
					out_status_d = STAT_OK;
					out_data_d   = head_data;
					out_len_d    = cnt_q;
					out_last_d   = ({1'b0, dump_idx_q} + 1'b1) == {1'b0, cnt_q};
					dump_idx_d   = dump_idx_q + 1'b1;
					if (out_last_d) state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			dump_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			dump_idx_q <= dump_idx_d;
			if (out_load) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		status_s1 <= status_d;
		if (out_load) begin
			out_status_q <= out_status_d;
			out_data_q   <= out_data_d;
			out_len_q    <= out_len_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {7'b0, out_len_q, out_data_q, out_status_q};

	// count stays within capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_V)
		else $error("entry count above capacity");

	// an edit result always lands in the output register
	a_finish_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FINISH |=> m_tvalid)
		else $error("edit result not presented");

	// only a dump produces non-final results
	a_notlast_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> state_q == S_DUMP)
		else $error("non-final result outside dump");

	// count moves only after an accepted request
	a_cnt_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> $stable(cnt_q))
		else $error("count changed without a request");

endmodule

// ----- bench/array_list_insert_delete_test.sv -----
// Self-checking bench for the array list block: command stream in, checked result stream out.
module array_list_insert_delete_test;
	import ali_pkg::*;

	localparam int LIST_CAP     = 64;
	localparam int HALF_PERIOD  = 6;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int STALL_CYCLES = 250;
	localparam int SETTLE       = 20;

	// Command codes with no operation behind them
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	typedef enum {MIX_EDIT, MIX_FILL, MIX_DRAIN} mix_t;

	// One queued request; a hold entry makes the sender wait for all results
	typedef struct {
		bit                       hold;
		logic [CMD_W-1:0]         cmd;
		logic [CNT_W-1:0]         pos;
		logic signed [DATA_W-1:0] val;
	} list_req_t;

	typedef struct {
		status_t                  status;
		logic signed [DATA_W-1:0] data;
		logic [CNT_W-1:0]         length;
		logic                     last;
	} list_rsp_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;  // command[2:0], position[9:3], value[41:10], zero pad
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // status[1:0], data_out[33:2], length[40:34], zero pad
	logic        m_tlast;

	list_req_t pending_reqs[$];
	list_rsp_t expected_rsps[$];

	// Predicted list contents and length
	logic signed [DATA_W-1:0] model_list [LIST_CAP];
	int unsigned              model_len = 0;

	// Length as the stimulus generator sees it, used to aim positions
	int unsigned gen_len = 0;

	int  err_count  = 0;
	int  sent_items = 0;
	bit  in_taken   = 1'b0;
	bit  stall_done = 1'b0;
	int  stall_left = 0;
	wire calm = (sent_items >= 100) && (sent_items < 140);

	array_list_insert_delete #(.CAPACITY(LIST_CAP)) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	task automatic queue_result(input status_t st, input logic signed [DATA_W-1:0] d,
			input logic lst);
		list_rsp_t r;
		r.status = st;
		r.data   = d;
		r.length = model_len[CNT_W-1:0];
		r.last   = lst;
		expected_rsps.push_back(r);
	endtask

	// Apply one accepted request to the predicted list and queue its results
	task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [CNT_W-1:0] pos,
			input logic signed [DATA_W-1:0] val);
		logic signed [DATA_W-1:0] taken;
		int unsigned i;
		case (cmd)
			CMD_APPEND: begin
				if (model_len >= LIST_CAP) begin
					queue_result(STAT_FULL, '0, 1'b1);
				end else begin
					model_list[model_len] = val;
					model_len++;
					queue_result(STAT_OK, '0, 1'b1);
				end
			end
			CMD_DEL_LAST: begin
				if (model_len == 0) begin
					queue_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					model_len--;
					queue_result(STAT_OK, model_list[model_len], 1'b1);
				end
			end
			CMD_INSERT: begin
				if (model_len >= LIST_CAP) begin
					queue_result(STAT_FULL, '0, 1'b1);
				end else if (pos > model_len) begin
					queue_result(STAT_BOUNDS, '0, 1'b1);
				end else begin
					for (i = model_len; i > pos; i--)
						model_list[i] = model_list[i-1];
					model_list[pos] = val;
					model_len++;
					queue_result(STAT_OK, '0, 1'b1);
				end
			end
			CMD_DEL_AT: begin
				if (pos >= model_len) begin
					queue_result(STAT_BOUNDS, '0, 1'b1);
				end else begin
					taken = model_list[pos];
					for (i = pos; i + 1 < model_len; i++)
						model_list[i] = model_list[i+1];
					model_len--;
					queue_result(STAT_OK, taken, 1'b1);
				end
			end
			CMD_DUMP: begin
				if (model_len == 0) begin
					queue_result(STAT_EMPTY, '0, 1'b1);
				end else begin
					for (i = 0; i < model_len; i++)
						queue_result(STAT_OK, model_list[i], i + 1 == model_len);
				end
			end
			default: queue_result(STAT_OK, '0, 1'b1);
		endcase
	endtask

	// Stimulus helpers
	task automatic add_req(input logic [CMD_W-1:0] cmd, input int pos,
			input logic signed [DATA_W-1:0] val);
		list_req_t r;
		r.hold = 1'b0;
		r.cmd  = cmd;
		r.pos  = pos[CNT_W-1:0];
		r.val  = val;
		pending_reqs.push_back(r);
		case (cmd)
			CMD_APPEND:   if (gen_len < LIST_CAP) gen_len++;
			CMD_DEL_LAST: if (gen_len > 0) gen_len--;
			CMD_INSERT:   if (gen_len < LIST_CAP && pos <= gen_len) gen_len++;
			CMD_DEL_AT:   if (pos < gen_len) gen_len--;
			default: ;
		endcase
	endtask

	task automatic add_hold();
		list_req_t r;
		r.hold = 1'b1;
		r.cmd  = '0;
		r.pos  = '0;
		r.val  = '0;
		pending_reqs.push_back(r);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return '0;
			3:       return -1;
			default: return $urandom;
		endcase
	endfunction

	// Random edit; positions mostly aimed inside the current list
	task automatic add_random(input mix_t mix);
		int r;
		int p;
		logic [CMD_W-1:0] cmd;
		r = $urandom_range(99);
		case (mix)
			MIX_EDIT:
				cmd = (r < 28) ? CMD_APPEND : (r < 43) ? CMD_DEL_LAST : (r < 65) ? CMD_INSERT :
					(r < 88) ? CMD_DEL_AT : (r < 96) ? CMD_DUMP :
					CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST));
			MIX_FILL:
				cmd = (r < 55) ? CMD_APPEND : (r < 93) ? CMD_INSERT : (r < 96) ? CMD_DEL_AT :
					(r < 98) ? CMD_DEL_LAST : CMD_DUMP;
			default:
				cmd = (r < 35) ? CMD_DEL_LAST : (r < 75) ? CMD_DEL_AT : (r < 85) ? CMD_APPEND :
					(r < 92) ? CMD_INSERT : CMD_DUMP;
		endcase
		p = $urandom_range(LIST_CAP);
		if ($urandom_range(99) < 80) begin
			if (cmd == CMD_INSERT)
				p = $urandom_range(gen_len);
			else if (cmd == CMD_DEL_AT && gen_len > 0)
				p = $urandom_range(gen_len - 1);
		end
		add_req(cmd, p, pick_value());
	endtask

	// Stimulus plan, then end-of-run check
	initial begin
		// empty-list cases
		add_req(CMD_DUMP, 0, 32'sh1234_5678);
		add_req(CMD_DEL_LAST, 0, 0);
		add_req(CMD_DEL_AT, 0, 0);
		add_req(CMD_INSERT, 1, 7);
		// build a short list at every edge position
		add_req(CMD_INSERT, 0, 32'sh8000_0000);
		add_req(CMD_APPEND, 0, 32'sh7FFF_FFFF);
		add_req(CMD_APPEND, LIST_CAP, -1);
		add_req(CMD_INSERT, 3, 0);
		add_req(CMD_INSERT, 1, 32'sh5555_5555);
		add_req(CMD_INSERT, LIST_CAP, 32'shAAAA_AAAA);
		add_req(CMD_DEL_AT, LIST_CAP, 0);
		add_req(CMD_DEL_AT, LIST_CAP - 1, 0);
		add_req(CMD_DEL_AT, 5, 0);
		add_req(CMD_DUMP, 0, 0);
		// remove head, tail, middle, then last
		add_req(CMD_DEL_AT, 0, 0);
		add_req(CMD_DEL_AT, 3, 0);
		add_req(CMD_DEL_AT, 1, 0);
		add_req(CMD_DEL_LAST, 0, 0);
		for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
			add_req(CMD_W'(c), $urandom_range(LIST_CAP), pick_value());
		add_req(CMD_DUMP, 0, 0);
		add_hold();

		repeat (15) add_random(MIX_EDIT);
		while (gen_len < LIST_CAP) add_random(MIX_FILL);

		// full-list cases; insert reports full before checking position
		add_req(CMD_APPEND, 0, 1);
		add_req(CMD_INSERT, LIST_CAP, 2);
		add_req(CMD_INSERT, 0, 3);
		add_req(CMD_DUMP, 0, 0);
		add_req(CMD_DEL_AT, LIST_CAP - 1, 0);
		add_req(CMD_INSERT, LIST_CAP - 1, pick_value());
		add_req(CMD_APPEND, 0, 4);
		add_hold();

		repeat (15) add_random(MIX_DRAIN);
		add_req(CMD_DUMP, 0, 0);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !s_tvalid && expected_rsps.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (err_count == 0 && expected_rsps.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Run limit
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	// Request driver
	always @(negedge clk) begin
		logic      nv;
		list_req_t head;
		nv = s_tvalid;
		if (s_tvalid && in_taken) begin
			void'(pending_reqs.pop_front());
			nv = 1'b0;
		end
		if (!nv && arst_n && pending_reqs.size() > 0) begin
			head = pending_reqs[0];
			if (head.hold) begin
				if (expected_rsps.size() == 0)
					void'(pending_reqs.pop_front());
			end else if (calm || $urandom_range(99) >= 30) begin
				nv = 1'b1;
				s_tdata <= {6'b0, head.val, head.pos, head.cmd};
			end
		end
		s_tvalid <= nv;
	end

	// Result ready, with one long hold-off while requests keep coming
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (!stall_done && sent_items >= 70) begin
			stall_done = 1'b1;
			stall_left = STALL_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= calm || $urandom_range(99) >= 30;
		end
	end

	// Monitor: check results, predict accepted requests
	always @(posedge clk) begin
		list_rsp_t want;
		status_t   got_status;
		logic signed [DATA_W-1:0] got_data;
		logic [CNT_W-1:0] got_len;
		in_taken = arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got_status = status_t'(m_tdata[1:0]);
			got_data   = m_tdata[33:2];
			got_len    = m_tdata[40:34];
			if (expected_rsps.size() == 0) begin
				$error("unexpected result: status %0d data_out %0d length %0d last %0b",
					got_status, got_data, got_len, m_tlast);
				err_count++;
			end else begin
				want = expected_rsps.pop_front();
				if (got_status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, got_status);
					err_count++;
				end
				if (got_data !== want.data) begin
					$error("data_out: expected %0d, actual %0d", want.data, got_data);
					err_count++;
				end
				if (got_len !== want.length) begin
					$error("length: expected %0d, actual %0d", want.length, got_len);
					err_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0b, actual %0b", want.last, m_tlast);
					err_count++;
				end
			end
		end
		if (in_taken) begin
			predict_request(s_tdata[2:0], s_tdata[9:3], s_tdata[41:10]);
			sent_items++;
		end
	end

endmodule
